>>> hw/rtl/hsvcw_pkg.sv
// Shared types, constants and tables for the HSV color wheel pixel core.
// No dependencies; used by every module under hw/rtl.
package hsvcw_pkg;

    // Field and register widths fixed by the block's interface
    localparam int RADIUS_W       = 11;
    localparam int ORIGIN_W       = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int CHAN_W         = 8;

    // Defaults for the top level parameters
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Squared distance: |dx|,|dy| <= radius
    localparam int R2_W = 2 * RADIUS_W;
    localparam int D2_W = 2 * RADIUS_W + 1;

    // CORDIC angle unit: Q0.32 turns
    localparam int CORDIC_ITERS    = 28;
    localparam int CORDIC_PRESHIFT = 28;
    localparam int CORDIC_XW       = RADIUS_W + CORDIC_PRESHIFT + 4;
    localparam int CORDIC_ZW       = 33;
    localparam int ANGLE_W         = 32;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

    // atan(2^-i) / (2*pi) in Q0.32 turns, rounded
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd2;

    // Hue sextants
    localparam logic [2:0] SEC_RED_YEL   = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN   = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU   = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG   = 3'd4;

    // Quadrant info that rides along the CORDIC pipe
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic ax_zero;
        logic ay_zero;
    } t_quad;

    // One result item
    typedef struct packed {
        logic              on_disc;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

endpackage

>>> hw/rtl/hsvcw_cordic.sv
// Pipelined CORDIC vectoring unit: first-quadrant angle plus quadrant to hue.
// Depends on hsvcw_pkg. Input register, one per iteration, one for the hue map.
module hsvcw_cordic #(
    parameter int FRAC_BITS = hsvcw_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [hsvcw_pkg::RADIUS_W-1:0]    i_ax,
    input  logic [hsvcw_pkg::RADIUS_W-1:0]    i_ay,
    input  hsvcw_pkg::t_quad                  i_quad,
    output logic [FRAC_BITS-1:0]              o_hue
);

    localparam int N  = hsvcw_pkg::CORDIC_ITERS;
    localparam int XW = hsvcw_pkg::CORDIC_XW;
    localparam int ZW = hsvcw_pkg::CORDIC_ZW;
    localparam int AW = hsvcw_pkg::ANGLE_W;

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    hsvcw_pkg::t_quad     r_q [N+1];
    logic [FRAC_BITS-1:0] r_hue;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(XW'(i_ax) << hsvcw_pkg::CORDIC_PRESHIFT);
            r_y[0] <= $signed(XW'(i_ay) << hsvcw_pkg::CORDIC_PRESHIFT);
            r_z[0] <= '0;
            r_q[0] <= i_quad;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign at = $signed({1'b0, hsvcw_pkg::ATAN_TURNS[i]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][XW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + at;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - at;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // Clamp to [0, quarter turn], exact axes, then place in the quadrant
    logic [AW-1:0] n_ang;
    logic [AW-1:0] n_hue32;

    always_comb begin
        if (r_q[N].ay_zero) begin
            n_ang = '0;
        end else if (r_q[N].ax_zero) begin
            n_ang = hsvcw_pkg::QUARTER_TURN;
        end else if (r_z[N][ZW-1]) begin
            n_ang = '0;
        end else if (r_z[N] > $signed({1'b0, hsvcw_pkg::QUARTER_TURN})) begin
            n_ang = hsvcw_pkg::QUARTER_TURN;
        end else begin
            n_ang = r_z[N][AW-1:0];
        end

        if (!r_q[N].dx_neg && !r_q[N].dy_neg) begin
            n_hue32 = hsvcw_pkg::HALF_TURN + n_ang;
        end else if (r_q[N].dx_neg && !r_q[N].dy_neg) begin
            n_hue32 = AW'(0) - n_ang;
        end else if (r_q[N].dx_neg) begin
            n_hue32 = n_ang;
        end else begin
            n_hue32 = hsvcw_pkg::HALF_TURN - n_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue <= n_hue32[AW-1 -: FRAC_BITS];
        end
    end

    assign o_hue = r_hue;

endmodule

>>> hw/rtl/hsvcw_sat.sv
// Saturation pipe: restoring divide d2/r2 to Q1.2F, then digit-by-digit sqrt.
// Depends on hsvcw_pkg. One quotient bit or one root bit per register stage.
module hsvcw_sat #(
    parameter int FRAC_BITS = hsvcw_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic                           i_inside,
    input  logic [hsvcw_pkg::D2_W-1:0]     i_d2,
    input  logic [hsvcw_pkg::R2_W-1:0]     i_r2,
    output logic                           o_valid,
    output logic                           o_inside,
    output logic [FRAC_BITS:0]             o_sat
);

    localparam int D2W = hsvcw_pkg::D2_W;
    localparam int R2W = hsvcw_pkg::R2_W;
    localparam int QW  = 2 * FRAC_BITS + 1;
    localparam int SQN = FRAC_BITS + 1;
    localparam int RMW = FRAC_BITS + 3;

    logic           r_dv_valid  [QW];
    logic           r_dv_inside [QW];
    logic [R2W-1:0] r_dv_rem    [QW];
    logic [QW-1:0]  r_dv_q      [QW];

    logic             r_sq_valid  [SQN];
    logic             r_sq_inside [SQN];
    logic [QW-1:0]    r_sq_q      [SQN];
    logic [RMW-1:0]   r_sq_rem    [SQN];
    logic [FRAC_BITS:0] r_sq_root [SQN];

    // Integer quotient bit: 1 only when d2 == r2 on the disc
    logic eq0;
    assign eq0 = (i_d2 == D2W'(i_r2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_inside[0] <= i_inside;
            r_dv_rem[0]    <= eq0 ? '0 : i_d2[R2W-1:0];
            r_dv_q[0]      <= QW'(eq0);
        end
    end

    for (genvar k = 1; k < QW; k++) begin : g_div
        logic [R2W:0] t;
        logic         ge;
        assign t  = {r_dv_rem[k-1], 1'b0};
        assign ge = (t >= {1'b0, i_r2});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_inside[k] <= r_dv_inside[k-1];
                r_dv_rem[k]    <= ge ? R2W'(t - {1'b0, i_r2}) : R2W'(t);
                r_dv_q[k]      <= {r_dv_q[k-1][QW-2:0], ge};
            end
        end
    end

    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        logic               p_valid;
        logic               p_inside;
        logic [QW-1:0]      p_q;
        logic [RMW-1:0]     p_rem;
        logic [FRAC_BITS:0] p_root;
        logic [QW:0]        pad;
        logic [1:0]         pair;
        logic [RMW-1:0]     rsh;
        logic [RMW-1:0]     trial;
        logic               ge;

        if (j == 0) begin : g_first
            assign p_valid  = r_dv_valid[QW-1];
            assign p_inside = r_dv_inside[QW-1];
            assign p_q      = r_dv_q[QW-1];
            assign p_rem    = '0;
            assign p_root   = '0;
        end else begin : g_next
            assign p_valid  = r_sq_valid[j-1];
            assign p_inside = r_sq_inside[j-1];
            assign p_q      = r_sq_q[j-1];
            assign p_rem    = r_sq_rem[j-1];
            assign p_root   = r_sq_root[j-1];
        end

        assign pad   = {1'b0, p_q};
        assign pair  = pad[2*FRAC_BITS+1-2*j -: 2];
        assign rsh   = {p_rem[FRAC_BITS:0], pair};
        assign trial = {p_root, 2'b01};
        assign ge    = (rsh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_sq_valid[j] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_inside[j] <= p_inside;
                r_sq_q[j]      <= p_q;
                r_sq_rem[j]    <= ge ? (rsh - trial) : rsh;
                r_sq_root[j]   <= {p_root[FRAC_BITS-1:0], ge};
            end
        end
    end

    assign o_valid  = r_sq_valid[SQN-1];
    assign o_inside = r_sq_inside[SQN-1];
    assign o_sat    = r_sq_root[SQN-1];

endmodule

>>> hw/rtl/hsv_color_wheel_pixel_core.sv
// Top level of the HSV color wheel pixel core: geometry, HSV to RGB, output skid.
// Depends on hsvcw_pkg, hsvcw_cordic and hsvcw_sat.
//
// One pixel coordinate goes in per clock while o_stall is low and one RGB
// item comes out per clock while i_stall is low, in order. The point is tested
// against the wheel's box and disc; on the disc, hue comes from the angle
// around the center and saturation from the distance over the radius, value
// is always full. The divider takes one quotient bit per stage
// (2*FRAC_BITS + 1 stages) and the square root one root bit per stage
// (FRAC_BITS + 1 stages), with the 28-step CORDIC angle running alongside.
// The whole pipe moves as one; it freezes only when the two-deep output
// buffer is full, so o_stall is a registered signal and an item is still
// accepted while a result waits. Configuration writes are taken at any time
// (o_cfg_ready is tied high) but must only be made while no item is in
// flight.
module hsv_color_wheel_pixel_core #(
    parameter int COORD_BITS = hsvcw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hsvcw_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel items in
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [COORD_BITS-1:0]              i_pos_x,
    input  logic [COORD_BITS-1:0]              i_pos_y,
    // color items out
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_inside_res,
    output logic [hsvcw_pkg::CHAN_W-1:0]       o_red,
    output logic [hsvcw_pkg::CHAN_W-1:0]       o_green,
    output logic [hsvcw_pkg::CHAN_W-1:0]       o_blue,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hsvcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsvcw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RW  = hsvcw_pkg::RADIUS_W;
    localparam int OW  = hsvcw_pkg::ORIGIN_W;
    localparam int CW  = hsvcw_pkg::CHAN_W;
    localparam int XW  = ((COORD_BITS > OW) ? COORD_BITS : OW) + 1;
    localparam int DW  = RW + 1;
    localparam int FB  = FRAC_BITS;
    // hue is ready before saturation; delay it to line up
    localparam int HUE_DLY = 3 * FRAC_BITS + 3 - (hsvcw_pkg::CORDIC_ITERS + 1);
    localparam logic [OW-1:0] ORG_MASK =
        (COORD_BITS >= OW) ? {OW{1'b1}} : OW'((1 << COORD_BITS) - 1);
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    // ---------------- configuration ----------------
    logic [RW-1:0]              r_radius;
    logic [OW-1:0]              r_origin_x;
    logic [OW-1:0]              r_origin_y;
    logic [hsvcw_pkg::R2_W-1:0] r_r2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RW'(64);
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hsvcw_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[RW-1:0];
                hsvcw_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data[OW-1:0];
                hsvcw_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    // r^2 follows radius next cycle; user keeps writes only when idle, not enforced
    always_ff @(posedge i_clk) begin
        r_r2 <= hsvcw_pkg::R2_W'(r_radius) * hsvcw_pkg::R2_W'(r_radius);
    end

    // ---------------- pipe enable ----------------
    logic r_skid_valid;
    logic en;
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // ---------------- S1: subtract origin ----------------
    logic                 r_s1_valid;
    logic signed [XW-1:0] r_s1_x;
    logic signed [XW-1:0] r_s1_y;
    logic signed [XW-1:0] n_s1_x;
    logic signed [XW-1:0] n_s1_y;

    assign n_s1_x = $signed({1'b0, (XW-1)'(i_pos_x)})
                  - $signed({1'b0, (XW-1)'(r_origin_x & ORG_MASK)});
    assign n_s1_y = $signed({1'b0, (XW-1)'(i_pos_y)})
                  - $signed({1'b0, (XW-1)'(r_origin_y & ORG_MASK)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x <= n_s1_x;
            r_s1_y <= n_s1_y;
        end
    end

    // ---------------- S2: box test, center offset ----------------
    logic                 r_s2_valid;
    logic                 r_s2_inbox;
    logic signed [DW-1:0] r_s2_dx;
    logic signed [DW-1:0] r_s2_dy;
    logic [XW-2:0]        two_r;
    logic                 n_s2_inbox;

    assign two_r      = (XW-1)'({r_radius, 1'b0});
    assign n_s2_inbox = !r_s1_x[XW-1] && (r_s1_x[XW-2:0] < two_r)
                     && !r_s1_y[XW-1] && (r_s1_y[XW-2:0] < two_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_inbox <= n_s2_inbox;
            r_s2_dx    <= DW'(r_s1_x - $signed({1'b0, (XW-1)'(r_radius)}));
            r_s2_dy    <= DW'(r_s1_y - $signed({1'b0, (XW-1)'(r_radius)}));
        end
    end

    // ---------------- S3: magnitudes and squares ----------------
    logic [DW-1:0]              abs_dx_w;
    logic [DW-1:0]              abs_dy_w;
    logic [RW-1:0]              ax;
    logic [RW-1:0]              ay;
    hsvcw_pkg::t_quad           quad;
    logic                       r_s3_valid;
    logic                       r_s3_inbox;
    logic [hsvcw_pkg::R2_W-1:0] r_s3_dx2;
    logic [hsvcw_pkg::R2_W-1:0] r_s3_dy2;

    // |dx|, |dy| <= radius on the box, so they fit in RW bits
    assign abs_dx_w = r_s2_dx[DW-1] ? DW'(-r_s2_dx) : DW'(r_s2_dx);
    assign abs_dy_w = r_s2_dy[DW-1] ? DW'(-r_s2_dy) : DW'(r_s2_dy);
    assign ax       = abs_dx_w[RW-1:0];
    assign ay       = abs_dy_w[RW-1:0];

    assign quad.dx_neg  = r_s2_dx[DW-1];
    assign quad.dy_neg  = r_s2_dy[DW-1];
    assign quad.ax_zero = (ax == '0);
    assign quad.ay_zero = (ay == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_inbox <= r_s2_inbox;
            r_s3_dx2   <= hsvcw_pkg::R2_W'(ax) * hsvcw_pkg::R2_W'(ax);
            r_s3_dy2   <= hsvcw_pkg::R2_W'(ay) * hsvcw_pkg::R2_W'(ay);
        end
    end

    // ---------------- S4: disc test ----------------
    logic                       r_s4_valid;
    logic                       r_s4_inside;
    logic [hsvcw_pkg::D2_W-1:0] r_s4_d2;
    logic [hsvcw_pkg::D2_W-1:0] n_s4_d2;

    assign n_s4_d2 = hsvcw_pkg::D2_W'(r_s3_dx2) + hsvcw_pkg::D2_W'(r_s3_dy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_inside <= r_s3_inbox && (n_s4_d2 <= hsvcw_pkg::D2_W'(r_r2));
            r_s4_d2     <= n_s4_d2;
        end
    end

    // ---------------- hue and saturation ----------------
    logic [FB-1:0] cordic_hue;
    logic          sat_valid;
    logic          sat_inside;
    logic [FB:0]   sat;

    hsvcw_cordic #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ax   (ax),
        .i_ay   (ay),
        .i_quad (quad),
        .o_hue  (cordic_hue)
    );

    hsvcw_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_s4_valid),
        .i_inside (r_s4_inside),
        .i_d2     (r_s4_d2),
        .i_r2     (r_r2),
        .o_valid  (sat_valid),
        .o_inside (sat_inside),
        .o_sat    (sat)
    );

    logic [FB-1:0] r_hue_dly [HUE_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue_dly[0] <= cordic_hue;
        end
    end

    for (genvar d = 1; d < HUE_DLY; d++) begin : g_hue_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hue_dly[d] <= r_hue_dly[d-1];
            end
        end
    end

    // ---------------- H1: sextant and fraction ----------------
    logic          r_h1_valid;
    logic          r_h1_inside;
    logic [FB:0]   r_h1_sat;
    logic [2:0]    r_h1_sector;
    logic [FB-1:0] r_h1_f;
    logic [FB+2:0] n_h6;

    assign n_h6 = (FB+3)'(r_hue_dly[HUE_DLY-1]) * (FB+3)'(6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_valid <= 1'b0;
        end else if (en) begin
            r_h1_valid <= sat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1_inside <= sat_inside;
            r_h1_sat    <= sat;
            r_h1_sector <= n_h6[FB+2:FB];
            r_h1_f      <= n_h6[FB-1:0];
        end
    end

    // ---------------- H2: p, q, t ----------------
    logic          r_h2_valid;
    logic          r_h2_inside;
    logic [2:0]    r_h2_sector;
    logic [FB:0]   r_h2_p;
    logic [FB:0]   r_h2_q;
    logic [FB:0]   r_h2_t;
    logic [FB:0]   one_m_f;
    logic [2*FB:0] prod_q;
    logic [2*FB:0] prod_t;

    assign one_m_f = ONE - (FB+1)'(r_h1_f);
    assign prod_q  = (2*FB+1)'(r_h1_sat) * (2*FB+1)'(r_h1_f);
    assign prod_t  = (2*FB+1)'(r_h1_sat) * (2*FB+1)'(one_m_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h2_valid <= 1'b0;
        end else if (en) begin
            r_h2_valid <= r_h1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h2_inside <= r_h1_inside;
            r_h2_sector <= r_h1_sector;
            r_h2_p      <= ONE - r_h1_sat;
            r_h2_q      <= ONE - (FB+1)'(prod_q >> FB);
            r_h2_t      <= ONE - (FB+1)'(prod_t >> FB);
        end
    end

    // ---------------- channel select and scale ----------------
    function automatic logic [CW-1:0] to_chan(input logic [FB:0] v);
        logic [FB+8:0] m;
        logic [8:0]    c;
        m = {v, 8'b0} - (FB+9)'(v);
        c = 9'(m >> FB);
        return (c > 9'd255) ? 8'd255 : c[CW-1:0];
    endfunction

    logic [FB:0]       sel_r;
    logic [FB:0]       sel_g;
    logic [FB:0]       sel_b;
    hsvcw_pkg::t_pixel n_res;

    always_comb begin
        case (r_h2_sector)
            hsvcw_pkg::SEC_RED_YEL: begin
                sel_r = ONE;    sel_g = r_h2_t; sel_b = r_h2_p;
            end
            hsvcw_pkg::SEC_YEL_GRN: begin
                sel_r = r_h2_q; sel_g = ONE;    sel_b = r_h2_p;
            end
            hsvcw_pkg::SEC_GRN_CYN: begin
                sel_r = r_h2_p; sel_g = ONE;    sel_b = r_h2_t;
            end
            hsvcw_pkg::SEC_CYN_BLU: begin
                sel_r = r_h2_p; sel_g = r_h2_q; sel_b = ONE;
            end
            hsvcw_pkg::SEC_BLU_MAG: begin
                sel_r = r_h2_t; sel_g = r_h2_p; sel_b = ONE;
            end
            default: begin
                sel_r = ONE;    sel_g = r_h2_p; sel_b = r_h2_q;
            end
        endcase

        // zero saturation gives p = q = t = one, i.e. white, with no extra case
        n_res.on_disc = r_h2_inside;
        n_res.red     = r_h2_inside ? to_chan(sel_r) : '0;
        n_res.green   = r_h2_inside ? to_chan(sel_g) : '0;
        n_res.blue    = r_h2_inside ? to_chan(sel_b) : '0;
    end

    // ---------------- output register + skid ----------------
    logic              r_out_valid;
    hsvcw_pkg::t_pixel r_out;
    hsvcw_pkg::t_pixel r_skid;
    logic              take;
    logic              to_out;

    assign take   = r_out_valid && !i_stall;
    assign to_out = !r_out_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            if (r_h2_valid) begin
                if (to_out) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end else if (take) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_h2_valid && to_out) begin
                r_out <= n_res;
            end
            if (r_h2_valid && !to_out) begin
                r_skid <= n_res;
            end
        end else if (take) begin
            r_out <= r_skid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out.on_disc;
    assign o_red        = r_out.red;
    assign o_green      = r_out.green;
    assign o_blue       = r_out.blue;

endmodule

>>> hw/rtl/hsvcw_checker.sv
// Port-level checker for hsv_color_wheel_pixel_core, with its bind.
// Depends on hsvcw_pkg for widths.
module hsvcw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_stall,
    input logic                          o_inside_res,
    input logic [hsvcw_pkg::CHAN_W-1:0] o_red,
    input logic [hsvcw_pkg::CHAN_W-1:0] o_green,
    input logic [hsvcw_pkg::CHAN_W-1:0] o_blue
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_inside_res) && $stable(o_red)
            && $stable(o_green) && $stable(o_blue))
        else $error("stalled item changed");

    // off the disc everything is black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_inside_res |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0)
        else $error("outside item has color");

    // full value: one channel is always at max
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_res |-> o_red == 8'd255 || o_green == 8'd255
            || o_blue == 8'd255)
        else $error("no channel at full value");

    // input backs up only behind a waiting result
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall with empty output");

    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("stall rose without output backpressure");

endmodule

bind hsv_color_wheel_pixel_core hsvcw_checker u_hsvcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_stall      (o_stall),
    .o_inside_res (o_inside_res),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue)
);

>>> tb/sv/hsvcw_color_checker.sv
`timescale 1ns / 100ps
// Color checker for the HSV color wheel pixel core: watches pixel, color and register channels.
// Computes the expected color of each accepted pixel and compares every result. Depends on hsvcw_pkg.
module hsvcw_color_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_inside_res,
    input  logic [7:0]  o_red,
    input  logic [7:0]  o_green,
    input  logic [7:0]  o_blue,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          mismatch_cnt,
    output int          colors_pending
);

    localparam int FRAC = 16;
    localparam longint ONE = 64'd1 << FRAC;

    logic [10:0]       wheel_r;
    logic [11:0]       wheel_ox, wheel_oy;
    hsvcw_pkg::t_pixel color_q[$];

    function automatic longint int_sqrt(longint n);
        longint res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // first-quadrant angle in Q0.32 turns
    function automatic longint quad_angle(longint ax, longint ay);
        longint xv, yv, z, nx, ny;
        z = 0;
        if (ay == 0) return 0;
        if (ax == 0) return 64'h4000_0000;
        xv = ax <<< hsvcw_pkg::CORDIC_PRESHIFT;
        yv = ay <<< hsvcw_pkg::CORDIC_PRESHIFT;
        for (int i = 0; i < hsvcw_pkg::CORDIC_ITERS; i++) begin
            if (yv >= 0) begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                z  = z + longint'(hsvcw_pkg::ATAN_TURNS[i]);
            end else begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                z  = z - longint'(hsvcw_pkg::ATAN_TURNS[i]);
            end
            xv = nx;
            yv = ny;
        end
        if (z < 0) z = 0;
        if (z > 64'h4000_0000) z = 64'h4000_0000;
        return z;
    endfunction

    function automatic logic [7:0] chan(longint v);
        longint c;
        c = (v * 255) >> FRAC;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic hsvcw_pkg::t_pixel wheel_color(logic [11:0] px, logic [11:0] py);
        hsvcw_pkg::t_pixel res;
        longint r, x, y, dx, dy, d2, r2, q, rem, s, a, hue32, hue, h6, f, p, qq, t;
        longint rc, gc, bc;
        logic [2:0] sector;
        res = '0;
        r = wheel_r;
        x = longint'(px) - longint'(wheel_ox);
        y = longint'(py) - longint'(wheel_oy);
        if (x < 0 || x >= 2 * r || y < 0 || y >= 2 * r) return res;
        dx = x - r;
        dy = y - r;
        d2 = dx * dx + dy * dy;
        r2 = r * r;
        if (d2 > r2) return res;
        res.on_disc = 1'b1;
        // long division to 2*FRAC fraction bits, then integer root
        q = d2 / r2;
        rem = d2 % r2;
        for (int k = 0; k < 2 * FRAC; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= r2) begin
                rem = rem - r2;
                q = q | 1;
            end
        end
        s = int_sqrt(q);
        if (s == 0) begin
            res.red = 8'd255; res.green = 8'd255; res.blue = 8'd255;
            return res;
        end
        a = quad_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dx >= 0 && dy >= 0)  hue32 = 64'h8000_0000 + a;
        else if (dx < 0 && dy >= 0) hue32 = 64'h1_0000_0000 - a;
        else if (dx < 0)         hue32 = a;
        else                     hue32 = 64'h8000_0000 - a;
        hue32 = hue32 & 64'hFFFF_FFFF;
        hue = hue32 >> (32 - FRAC);
        h6 = hue * 6;
        sector = 3'(h6 >> FRAC);
        f = h6 & (ONE - 1);
        p = ONE - s;
        qq = ONE - ((s * f) >> FRAC);
        t = ONE - ((s * (ONE - f)) >> FRAC);
        case (sector)
            hsvcw_pkg::SEC_RED_YEL: begin rc = ONE; gc = t;   bc = p;   end
            hsvcw_pkg::SEC_YEL_GRN: begin rc = qq;  gc = ONE; bc = p;   end
            hsvcw_pkg::SEC_GRN_CYN: begin rc = p;   gc = ONE; bc = t;   end
            hsvcw_pkg::SEC_CYN_BLU: begin rc = p;   gc = qq;  bc = ONE; end
            hsvcw_pkg::SEC_BLU_MAG: begin rc = t;   gc = p;   bc = ONE; end
            default:                begin rc = ONE; gc = p;   bc = qq;  end
        endcase
        res.red = chan(rc);
        res.green = chan(gc);
        res.blue = chan(bc);
        return res;
    endfunction

    assign colors_pending = color_q.size();

    always @(posedge i_clk) begin
        hsvcw_pkg::t_pixel want;
        if (!i_rst_n) begin
            wheel_r  <= 11'd64;
            wheel_ox <= '0;
            wheel_oy <= '0;
            color_q.delete();
            mismatch_cnt <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hsvcw_pkg::CFG_RADIUS:   wheel_r  <= i_cfg_data[10:0];
                    hsvcw_pkg::CFG_ORIGIN_X: wheel_ox <= i_cfg_data;
                    hsvcw_pkg::CFG_ORIGIN_Y: wheel_oy <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (color_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected color item", $realtime);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    want = color_q.pop_front();
                    if (want.on_disc !== o_inside_res || want.red !== o_red ||
                        want.green !== o_green || want.blue !== o_blue) begin
                        if (mismatch_cnt < 10)
                            $display({"%0t: color mismatch exp in=%0d rgb=%0d,%0d,%0d",
                                      " got in=%0d rgb=%0d,%0d,%0d"},
                                     $realtime, want.on_disc, want.red, want.green,
                                     want.blue, o_inside_res, o_red, o_green, o_blue);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            if (i_valid && !o_stall)
                color_q.push_back(wheel_color(i_pos_x, i_pos_y));
        end
    end
endmodule

>>> tb/sv/tb_hsv_color_wheel_pixel_core.sv
`timescale 1ns / 100ps
// Testbench top for the HSV color wheel pixel core: clock, reset, pixel and register stimulus.
// Depends on hsvcw_pkg, hsv_color_wheel_pixel_core and hsvcw_color_checker.
module tb_hsv_color_wheel_pixel_core;

    // pipe is 57 deep plus the output buffer; give it room
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid, i_stall;
    logic [11:0] i_pos_x, i_pos_y;
    logic        o_inside_res;
    logic [7:0]  o_red, o_green, o_blue;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    int          mismatch_cnt, colors_pending;
    int          burst_left;
    bit          hold_req, hold_done;
    int          hold_left;
    logic [10:0] cur_r;
    logic [11:0] cur_ox, cur_oy;

    hsv_color_wheel_pixel_core DUT (.*);
    hsvcw_color_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall pattern, with one long hold-off on request so
    // the output buffer fills and the pipe pushes back on the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left <= 300;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            // calm stretches alternate with choppy ones
            case (($time / 400) % 3)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // One pixel item; valid stays up across a burst, gaps fall between bursts.
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1)) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (colors_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // valid stays up between back-to-back writes; the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_wheel(input logic [10:0] r, input logic [11:0] ox, input logic [11:0] oy);
        wait_idle();
        write_reg(hsvcw_pkg::CFG_RADIUS, {1'b0, r});
        write_reg(hsvcw_pkg::CFG_ORIGIN_X, ox);
        write_reg(hsvcw_pkg::CFG_ORIGIN_Y, oy);
        i_cfg_valid <= 1'b0;
        cur_r = r; cur_ox = ox; cur_oy = oy;
    endtask

    // Mostly points in the wheel's box, some anywhere on the screen.
    task automatic random_pixels(input int n);
        logic [11:0] px, py;
        for (int k = 0; k < n; k++) begin
            if (cur_r != 0 && $urandom_range(0, 9) < 7) begin
                px = cur_ox + 12'($urandom_range(0, 2 * cur_r - 1));
                py = cur_oy + 12'($urandom_range(0, 2 * cur_r - 1));
            end else begin
                px = 12'($urandom);
                py = 12'($urandom);
            end
            send_pixel(px, py);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = hsvcw_pkg::CFG_RADIUS;
        i_cfg_data = '0;
        burst_left = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        cur_r = 11'd64; cur_ox = '0; cur_oy = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset wheel r=64 at the origin
        send_pixel(12'd64, 12'd64);     // center: white
        send_pixel(12'd65, 12'd64);     // next to center
        send_pixel(12'd0, 12'd64);      // left rim, full turn wraps to hue 0
        send_pixel(12'd127, 12'd64);    // right rim
        send_pixel(12'd64, 12'd0);      // top rim
        send_pixel(12'd64, 12'd127);    // bottom rim
        send_pixel(12'd128, 12'd64);    // just past the box
        send_pixel(12'd64, 12'd128);
        send_pixel(12'd0, 12'd0);       // box corner, off the disc
        send_pixel(12'd127, 12'd127);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd100, 12'd30);    // one point per quadrant
        send_pixel(12'd30, 12'd30);
        send_pixel(12'd30, 12'd100);
        send_pixel(12'd100, 12'd100);
        send_pixel(12'd109, 12'd19);    // diagonal on the rim
        send_pixel(12'd64, 12'd63);
        send_pixel(12'd63, 12'd64);

        random_pixels(80);
        set_wheel(11'd1, 12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);       // center of a radius-one wheel
        random_pixels(40);
        set_wheel(11'd0, 12'd5, 12'd5); // empty box
        send_pixel(12'd5, 12'd5);
        random_pixels(20);
        set_wheel(11'd2047, 12'd0, 12'd0);
        hold_req = 1'b1;                // long receiver hold-off during this phase
        random_pixels(120);
        set_wheel(11'd2047, 12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        random_pixels(60);
        set_wheel(11'd100, 12'd4095, 12'd0);
        random_pixels(60);
        for (int ph = 0; ph < 6; ph++) begin
            set_wheel(11'($urandom_range(1, 300)), 12'($urandom), 12'($urandom));
            random_pixels(60);
        end
        set_wheel(11'($urandom_range(1, 2047)), 12'($urandom_range(0, 2000)),
                  12'($urandom_range(0, 2000)));
        random_pixels(50);

        wait_idle();
        if (mismatch_cnt == 0 && colors_pending == 0)
            $display("** hsv_color_wheel_pixel_core: PASSED **");
        else
            $display("** hsv_color_wheel_pixel_core: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** hsv_color_wheel_pixel_core: FAILED **");
        $finish;
    end
endmodule
